### rtl/core/okl_pkg.sv
// okl_pkg: shared widths, stage counts and coefficient tables of the oklab converter
package okl_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int COEF_SHIFT = 28;
  localparam int FIELD_W    = 20;
  localparam int COEF_W     = 32;
  localparam int X_W        = 32;
  localparam int PROD_W     = COEF_W + X_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int Y_W        = SUM_W - COEF_SHIFT;
  localparam int MID_W      = 22;
  localparam int MAG_W      = MID_W;
  localparam int CUBE_IN_W  = MAG_W - 1;
  localparam int CUBE_W     = 31;
  localparam int CUBE_FULL_W = 3 * CUBE_IN_W + 1;
  localparam int N_W        = MAG_W + 2 * FRAC_BITS;
  localparam int ROOT_W     = (N_W + 2) / 3;
  localparam int Y2_W       = 2 * ROOT_W;
  localparam int CB_W       = N_W + 3;
  localparam int NL_W       = 32;

  localparam int MAT_STAGES = 2;
  localparam int NL_FIRST   = MAT_STAGES;
  localparam int MAT2_FIRST = MAT_STAGES + ROOT_W;
  localparam int NUM_STAGES = 2 * MAT_STAGES + ROOT_W;

  localparam logic [CUBE_W-1:0] CUBE_MAX = {CUBE_W{1'b1}} >> 1;
  localparam logic signed [Y_W-1:0] OUT_MAX = Y_W'(524287);
  localparam logic signed [Y_W-1:0] OUT_MIN = -Y_W'(524288);

  localparam logic ADDR_DIRECTION = 1'b0;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t mat_t [3][3];

  function automatic coef_t coef(input logic [63:0] n);
    logic [127:0] p;
    p = ({64'd0, n} << COEF_SHIFT) + 128'd5000000000;
    p = p / 128'd10000000000;
    return coef_t'(p[COEF_W-1:0]);
  endfunction

  localparam mat_t FWD_LMS = '{
    '{coef(64'd4122214708), coef(64'd5363325363), coef(64'd514459929)},
    '{coef(64'd2119034982), coef(64'd6806995451), coef(64'd1073969566)},
    '{coef(64'd883024619),  coef(64'd2817188376), coef(64'd6299787005)}
  };

  localparam mat_t FWD_LAB = '{
    '{coef(64'd2104542553),  coef(64'd7936177850),   -coef(64'd40720468)},
    '{coef(64'd19779984951), -coef(64'd24285922050), coef(64'd4505937099)},
    '{coef(64'd259040371),   coef(64'd7827717662),   -coef(64'd8086757660)}
  };

  localparam mat_t INV_LMS = '{
    '{coef(64'd10000000000), coef(64'd3963377774),  coef(64'd2158037573)},
    '{coef(64'd10000000000), -coef(64'd1055613458), -coef(64'd638541728)},
    '{coef(64'd10000000000), -coef(64'd894841775),  -coef(64'd12914855480)}
  };

  localparam mat_t INV_RGB = '{
    '{coef(64'd40767416621),  -coef(64'd33077115913), coef(64'd2309699292)},
    '{-coef(64'd12684380046), coef(64'd26097574011),  -coef(64'd3413193965)},
    '{-coef(64'd41960863),    -coef(64'd7034186147),  coef(64'd17076147010)}
  };

endpackage

### rtl/core/oklab_color_converter.sv
// oklab_color_converter: top level, register port, stage control and output saturation
// One pixel enters per clock when nothing stalls. The depth comes from a 3x3 matrix
// (multiply, then sum), an 18-stage cube root that settles one result bit per stage (the
// inverse cube path runs alongside and is delayed to match), and a second 3x3 matrix. Each
// stage moves on when the stage after it is empty or moving, so empty slots are squeezed
// out while the output is stalled and requests are still taken until the pipe is full.
// The direction register may only be written while the pipe is empty.
module oklab_color_converter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                valid,
  output logic                                stall,
  input  logic signed [okl_pkg::FIELD_W-1:0]  comp_first,
  input  logic signed [okl_pkg::FIELD_W-1:0]  comp_second,
  input  logic signed [okl_pkg::FIELD_W-1:0]  comp_third,
  output logic                                res_valid,
  input  logic                                res_stall,
  output logic signed [okl_pkg::FIELD_W-1:0]  res_first,
  output logic signed [okl_pkg::FIELD_W-1:0]  res_second,
  output logic signed [okl_pkg::FIELD_W-1:0]  res_third,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam int NS = okl_pkg::NUM_STAGES;

  logic            direction;
  logic [NS-1:0]   vld;
  logic [NS-1:0]   en;

  logic signed [okl_pkg::X_W-1:0]  x1  [3];
  logic signed [okl_pkg::Y_W-1:0]  y1  [3];
  logic signed [okl_pkg::X_W-1:0]  x2  [3];
  logic signed [okl_pkg::Y_W-1:0]  y2  [3];
  logic signed [okl_pkg::FIELD_W-1:0] res [3];
  okl_pkg::mat_t coef1;
  okl_pkg::mat_t coef2;

  // register port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == okl_pkg::ADDR_DIRECTION) begin
      direction <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == okl_pkg::ADDR_DIRECTION) ? {31'd0, direction} : 32'd0;

  // stage control
  always_comb begin
    en[NS-1] = !vld[NS-1] || !res_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign stall     = !en[0];
  assign res_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // datapath
  assign coef1 = direction ? okl_pkg::INV_LMS : okl_pkg::FWD_LMS;
  assign coef2 = direction ? okl_pkg::INV_RGB : okl_pkg::FWD_LAB;

  assign x1[0] = okl_pkg::X_W'(comp_first);
  assign x1[1] = okl_pkg::X_W'(comp_second);
  assign x1[2] = okl_pkg::X_W'(comp_third);

  okl_matrix u_mat1 (
    .clk  (clk),
    .en   (en[okl_pkg::MAT_STAGES-1:0]),
    .coef (coef1),
    .x    (x1),
    .y    (y1)
  );

  for (genvar i = 0; i < 3; i++) begin : g_lane
    okl_lane u_lane (
      .clk    (clk),
      .dir    (direction),
      .en     (en[okl_pkg::MAT2_FIRST-1:okl_pkg::NL_FIRST]),
      .mid    (y1[i][okl_pkg::MID_W-1:0]),
      .result (x2[i])
    );
  end

  okl_matrix u_mat2 (
    .clk  (clk),
    .en   (en[NS-1:okl_pkg::MAT2_FIRST]),
    .coef (coef2),
    .x    (x2),
    .y    (y2)
  );

  // saturate to the field range
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      if (y2[r] > okl_pkg::OUT_MAX) begin
        res[r] = okl_pkg::FIELD_W'(okl_pkg::OUT_MAX);
      end else if (y2[r] < okl_pkg::OUT_MIN) begin
        res[r] = okl_pkg::FIELD_W'(okl_pkg::OUT_MIN);
      end else begin
        res[r] = y2[r][okl_pkg::FIELD_W-1:0];
      end
    end
  end

  assign res_first  = res[0];
  assign res_second = res[1];
  assign res_third  = res[2];

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (valid && !stall) |=> vld[0])
    else $error("accepted request did not enter the first stage");

  a_empty_out_no_stall: assert property (@(posedge clk) disable iff (rst)
    !vld[NS-1] |-> !stall)
    else $error("input stalled while the output stage is empty");

  a_held_stage_keeps: assert property (@(posedge clk) disable iff (rst)
    (vld[1] && !en[1]) |=> vld[1])
    else $error("held stage lost its request");

endmodule

### rtl/core/okl_matrix.sv
// okl_matrix: two-stage 3x3 fixed-point matrix multiply with rounding
module okl_matrix (
  input  logic                                clk,
  input  logic [1:0]                          en,
  input  okl_pkg::mat_t                       coef,
  input  logic signed [okl_pkg::X_W-1:0]      x [3],
  output logic signed [okl_pkg::Y_W-1:0]      y [3]
);

  logic signed [okl_pkg::PROD_W-1:0] prod [3][3];
  logic signed [okl_pkg::SUM_W-1:0]  sum  [3];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= okl_pkg::PROD_W'(coef[r][c]) * okl_pkg::PROD_W'(x[c]);
        end
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = okl_pkg::SUM_W'(prod[r][0]) + okl_pkg::SUM_W'(prod[r][1])
             + okl_pkg::SUM_W'(prod[r][2])
             + (okl_pkg::SUM_W'(1) <<< (okl_pkg::COEF_SHIFT - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int r = 0; r < 3; r++) begin
        y[r] <= okl_pkg::Y_W'(sum[r] >>> okl_pkg::COEF_SHIFT);
      end
    end
  end

endmodule

### rtl/core/okl_lane.sv
// okl_lane: pipelined signed cube root (one result bit per stage) and signed cube of one component
module okl_lane (
  input  logic                                  clk,
  input  logic                                  dir,
  input  logic [okl_pkg::ROOT_W-1:0]            en,
  input  logic signed [okl_pkg::MID_W-1:0]      mid,
  output logic signed [okl_pkg::NL_W-1:0]       result
);

  localparam int RW = okl_pkg::ROOT_W;

  logic [okl_pkg::MAG_W-1:0]     mag_in;
  logic [okl_pkg::CUBE_IN_W-1:0] cin;

  logic [okl_pkg::MAG_W-1:0]     mag [RW];
  logic                          neg [RW];
  logic [RW-1:0]                 y   [RW];
  logic [okl_pkg::Y2_W-1:0]      y2  [RW];
  logic [okl_pkg::CB_W-1:0]      y3  [RW];

  logic [2*okl_pkg::CUBE_IN_W-1:0] sq;
  logic [2*okl_pkg::CUBE_IN_W-1:0] plo;
  logic [2*okl_pkg::CUBE_IN_W-1:0] phi;
  logic [okl_pkg::CUBE_IN_W-1:0]   cm;
  logic [okl_pkg::CUBE_FULL_W-1:0] cfull;
  logic [okl_pkg::CUBE_FULL_W-1:0] cshift;
  logic [okl_pkg::CUBE_W-1:0]      cv [2:RW-1];

  assign mag_in = mid[okl_pkg::MID_W-1] ? okl_pkg::MAG_W'(-mid) : okl_pkg::MAG_W'(mid);
  assign cin    = mag_in[okl_pkg::MAG_W-1] ? {okl_pkg::CUBE_IN_W{1'b1}}
                                           : mag_in[okl_pkg::CUBE_IN_W-1:0];
  assign cm     = mag[0][okl_pkg::MAG_W-1] ? {okl_pkg::CUBE_IN_W{1'b1}}
                                           : mag[0][okl_pkg::CUBE_IN_W-1:0];

  // cube: square, split product, then round and clamp
  always_ff @(posedge clk) begin
    if (en[0]) begin
      sq <= (2*okl_pkg::CUBE_IN_W)'(cin) * (2*okl_pkg::CUBE_IN_W)'(cin);
    end
    if (en[1]) begin
      plo <= (2*okl_pkg::CUBE_IN_W)'(sq[okl_pkg::CUBE_IN_W-1:0])
           * (2*okl_pkg::CUBE_IN_W)'(cm);
      phi <= (2*okl_pkg::CUBE_IN_W)'(sq[2*okl_pkg::CUBE_IN_W-1:okl_pkg::CUBE_IN_W])
           * (2*okl_pkg::CUBE_IN_W)'(cm);
    end
  end

  always_comb begin
    cfull  = (okl_pkg::CUBE_FULL_W'(phi) << okl_pkg::CUBE_IN_W) + okl_pkg::CUBE_FULL_W'(plo)
           + (okl_pkg::CUBE_FULL_W'(1) << (2 * okl_pkg::FRAC_BITS - 1));
    cshift = cfull >> (2 * okl_pkg::FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      cv[2] <= (cshift > okl_pkg::CUBE_FULL_W'(okl_pkg::CUBE_MAX)) ? okl_pkg::CUBE_MAX
                                                                 : okl_pkg::CUBE_W'(cshift);
    end
  end

  for (genvar k = 3; k < RW; k++) begin : g_cdly
    always_ff @(posedge clk) begin
      if (en[k]) begin
        cv[k] <= cv[k-1];
      end
    end
  end

  // cube root: one bit per stage, from the top bit down
  for (genvar k = 0; k < RW; k++) begin : g_root
    localparam int B = RW - 1 - k;
    logic [okl_pkg::MAG_W-1:0] mi;
    logic                      ni;
    logic [RW-1:0]             yi;
    logic [okl_pkg::Y2_W-1:0]  y2i;
    logic [okl_pkg::CB_W-1:0]  y3i;
    logic [okl_pkg::CB_W-1:0]  ye;
    logic [okl_pkg::CB_W-1:0]  y2e;
    logic [okl_pkg::CB_W-1:0]  t3;
    logic [okl_pkg::CB_W-1:0]  n;

    if (k == 0) begin : g_first
      assign mi  = mag_in;
      assign ni  = mid[okl_pkg::MID_W-1];
      assign yi  = '0;
      assign y2i = '0;
      assign y3i = '0;
    end else begin : g_next
      assign mi  = mag[k-1];
      assign ni  = neg[k-1];
      assign yi  = y[k-1];
      assign y2i = y2[k-1];
      assign y3i = y3[k-1];
    end

    always_comb begin
      ye  = okl_pkg::CB_W'(yi);
      y2e = okl_pkg::CB_W'(y2i);
      t3  = y3i + ((y2e + (y2e << 1)) << B) + ((ye + (ye << 1)) << (2 * B))
          + (okl_pkg::CB_W'(1) << (3 * B));
      n   = okl_pkg::CB_W'(mi) << (2 * okl_pkg::FRAC_BITS);
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        mag[k] <= mi;
        neg[k] <= ni;
        if (t3 <= n) begin
          y[k]  <= yi | (RW'(1) << B);
          y2[k] <= y2i + (okl_pkg::Y2_W'(yi) << (B + 1)) + (okl_pkg::Y2_W'(1) << (2 * B));
          y3[k] <= t3;
        end else begin
          y[k]  <= yi;
          y2[k] <= y2i;
          y3[k] <= y3i;
        end
      end
    end
  end

  always_comb begin
    if (dir) begin
      result = neg[RW-1] ? -okl_pkg::NL_W'(cv[RW-1]) : okl_pkg::NL_W'(cv[RW-1]);
    end else begin
      result = neg[RW-1] ? -okl_pkg::NL_W'(y[RW-1]) : okl_pkg::NL_W'(y[RW-1]);
    end
  end

endmodule

### bench/oklab_color_converter_tb.sv
// oklab_color_converter_tb: self-checking bench for the rgb/oklab pixel converter
module oklab_color_converter_tb;

  typedef logic signed [okl_pkg::FIELD_W-1:0] px_t;
  typedef struct {
    px_t c0, c1, c2;
  } pixel_t;

  class pixel_scoreboard;
    pixel_t pending[$];
    int mismatches;
    int failed;
    bit dir;

    function automatic longint signed row_round(longint signed s);
      return (s + (64'sd1 <<< 27)) >>> 28;
    endfunction

    function automatic longint signed cbrt_signed(longint signed x);
      logic [127:0] n, c, t;
      longint unsigned mag;
      logic [23:0] y;
      mag = x < 0 ? -x : x;
      n = {64'd0, mag} << (2 * okl_pkg::FRAC_BITS);
      y = '0;
      for (int b = 23; b >= 0; b--) begin
        t = 128'(y | (24'd1 << b));
        c = t * t * t;
        if (c <= n) y = y | (24'd1 << b);
      end
      return x < 0 ? -longint'(y) : longint'(y);
    endfunction

    function automatic longint signed cube_signed(longint signed v);
      longint unsigned mag, c;
      mag = v < 0 ? -v : v;
      if (mag > 64'h1FFFFF) mag = 64'h1FFFFF;
      c = (mag * mag * mag + (64'd1 << (2 * okl_pkg::FRAC_BITS - 1)))
          >> (2 * okl_pkg::FRAC_BITS);
      if (c > 64'd1073741823) c = 64'd1073741823;
      return v < 0 ? -longint'(c) : longint'(c);
    endfunction

    function automatic px_t sat(longint signed v);
      if (v > 524287) v = 524287;
      if (v < -524288) v = -524288;
      return px_t'(v);
    endfunction

    function automatic pixel_t convert(pixel_t p);
      longint signed x[3], m[3], y[3];
      pixel_t r;
      x[0] = p.c0; x[1] = p.c1; x[2] = p.c2;
      for (int i = 0; i < 3; i++)
        m[i] = row_round(
          (dir ? okl_pkg::INV_LMS[i][0] : okl_pkg::FWD_LMS[i][0]) * x[0] +
          (dir ? okl_pkg::INV_LMS[i][1] : okl_pkg::FWD_LMS[i][1]) * x[1] +
          (dir ? okl_pkg::INV_LMS[i][2] : okl_pkg::FWD_LMS[i][2]) * x[2]);
      for (int i = 0; i < 3; i++)
        m[i] = dir ? cube_signed(m[i]) : cbrt_signed(m[i]);
      for (int i = 0; i < 3; i++)
        y[i] = row_round(
          (dir ? okl_pkg::INV_RGB[i][0] : okl_pkg::FWD_LAB[i][0]) * m[0] +
          (dir ? okl_pkg::INV_RGB[i][1] : okl_pkg::FWD_LAB[i][1]) * m[1] +
          (dir ? okl_pkg::INV_RGB[i][2] : okl_pkg::FWD_LAB[i][2]) * m[2]);
      r.c0 = sat(y[0]); r.c1 = sat(y[1]); r.c2 = sat(y[2]);
      return r;
    endfunction

    function void note_request(pixel_t p);
      pending.push_back(convert(p));
    endfunction

    function void check_result(pixel_t got);
      pixel_t e;
      if (pending.size() == 0) begin
        failed++;
        if (mismatches++ < 10) $display("unexpected result %0d %0d %0d", got.c0, got.c1, got.c2);
        return;
      end
      e = pending.pop_front();
      if (e.c0 !== got.c0 || e.c1 !== got.c1 || e.c2 !== got.c2) begin
        failed++;
        if (mismatches++ < 10)
          $display("mismatch exp %0d %0d %0d got %0d %0d %0d",
                   e.c0, e.c1, e.c2, got.c0, got.c1, got.c2);
      end
    endfunction
  endclass

  logic clk, rst, valid, stall, res_valid, res_stall, psel, penable, pwrite, pready;
  px_t comp_first, comp_second, comp_third, res_first, res_second, res_third;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  int send_idle, recv_idle, hold_cycles, quiet;
  pixel_scoreboard sb;

  oklab_color_converter i_dut (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // receiver side
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) sb.check_result('{res_first, res_second, res_third});
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      res_stall <= 1;
    end else
      res_stall <= ($urandom_range(99) < recv_idle);
  end

  always @(posedge clk) begin
    if (rst || (valid && !stall) || (res_valid && !res_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic px_t rand_field();
    case ($urandom_range(7))
      0: return 20'sh7FFFF;
      1: return 20'sh80000;
      2: return px_t'($urandom_range(65536));
      3: return -px_t'($urandom_range(65536));
      default: return px_t'($urandom);
    endcase
  endfunction

  task automatic send_pixel(px_t a, px_t b, px_t c);
    while ($urandom_range(99) < send_idle) begin
      valid <= 0;
      @(posedge clk);
    end
    valid <= 1; comp_first <= a; comp_second <= b; comp_third <= c;
    do @(posedge clk); while (stall);
    sb.note_request('{a, b, c});
  endtask

  task automatic drain();
    valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_direction(bit d);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= 3'(okl_pkg::ADDR_DIRECTION) << 2; pwdata <= {31'd0, d};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.dir = d;
  endtask

  task automatic run_phase(bit d, int count);
    px_t edges[5];
    edges = '{20'sh7FFFF, 20'sh80000, 20'sd0, 20'sd65536, -20'sd65536};
    drain();
    write_direction(d);
    foreach (edges[i])
      foreach (edges[j]) if (i < 4) send_pixel(edges[i], edges[j], edges[(i + j) % 5]);
    repeat (count) send_pixel(rand_field(), rand_field(), rand_field());
  endtask

  initial begin
    sb = new();
    rst = 1; valid = 0; res_stall = 0; psel = 0; penable = 0; pwrite = 0;
    paddr = 0; pwdata = 0; comp_first = 0; comp_second = 0; comp_third = 0;
    send_idle = 30; recv_idle = 59; hold_cycles = 0; quiet = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    run_phase(0, 230);
    run_phase(1, 230);
    hold_cycles = 200;
    send_idle = 0;
    repeat (60) send_pixel(rand_field(), rand_field(), rand_field());
    drain();
    send_idle = 59; recv_idle = 30;
    run_phase(0, 230);
    run_phase(1, 230);
    send_idle = 0; recv_idle = 0;
    run_phase(0, 230);
    run_phase(1, 230);
    drain();
    if (sb.failed == 0 && sb.pending.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule

### filelist.f
rtl/core/okl_pkg.sv
rtl/core/okl_matrix.sv
rtl/core/okl_lane.sv
rtl/core/oklab_color_converter.sv
bench/oklab_color_converter_tb.sv
